// ===== rtl/rbd_pkg.sv =====
// ----------------------------------------------------------------------------
// rbd_pkg
// shared types and constants of the ring buffer deque
// ----------------------------------------------------------------------------
package rbd_pkg;

    // field widths fixed by the interface
    localparam int unsigned ACTION_W = 2;
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned CAP_W    = 5;

    // capacity after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // operation codes
    localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 2'd3;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [DATA_W-1:0]   value;
    } t_in_item;

    typedef struct packed {
        logic              ok;
        logic [DATA_W-1:0] popped;
        logic              is_empty;
        logic              is_full;
    } t_out_item;

    // controller to datapath commands
    typedef struct packed {
        logic exec;      // accepted operation, update pointers and access slots
        logic load_out;  // move pending result into output register
        logic cfg_wr;    // capacity write, clears the ring
    } t_dp_cmd;

endpackage

// ===== rtl/rbd_ctrl.sv =====
// ----------------------------------------------------------------------------
// rbd_ctrl
// handshake controller: input acceptance, result hand-off, config write
// ----------------------------------------------------------------------------
module rbd_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    output rbd_pkg::t_dp_cmd o_cmd
);
    import rbd_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_LOAD
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;
    logic   in_ready;
    logic   accept;
    logic   load_out;

    assign out_free = !r_out_valid || !i_out_stall;
    // a result in flight only blocks when it cannot move into the output register
    assign in_ready = (r_state == S_IDLE) || out_free;
    assign accept   = i_in_valid && in_ready;
    assign load_out = (r_state == S_LOAD) && out_free;

    assign o_in_stall  = !in_ready;
    assign o_out_valid = r_out_valid;
    // capacity write never shares a cycle with an operation transfer
    assign o_cfg_ready = (r_state == S_IDLE) && !i_in_valid;

    assign o_cmd.exec     = accept;
    assign o_cmd.load_out = load_out;
    assign o_cmd.cfg_wr   = i_cfg_valid && (r_state == S_IDLE) && !i_in_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                if (accept) begin
                    n_state = S_LOAD;
                end else if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        n_out_valid = r_out_valid;
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // a pending result exists in the cycle after a transfer or while held
    a_load_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_LOAD))
        else $error("pending result lost after input transfer");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) && !out_free |=> (r_state == S_LOAD))
        else $error("pending result dropped while output busy");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> !(r_out_valid && i_out_stall))
        else $error("output register overwritten while stalled");

endmodule

// ===== rtl/rbd_dpath.sv =====
// ----------------------------------------------------------------------------
// rbd_dpath
// pointers, slot memory, capacity register and result registers
// ----------------------------------------------------------------------------
module rbd_dpath #(
    parameter int unsigned DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rbd_pkg::t_dp_cmd    i_cmd,
    input  rbd_pkg::t_in_item   i_in_item,
    input  logic [rbd_pkg::CAP_W-1:0] i_cfg_data,
    output rbd_pkg::t_out_item  o_out_item
);
    import rbd_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = ((AW > CAP_W) ? AW : CAP_W) + 1;

    function automatic logic [AW-1:0] step_up(input logic [AW-1:0] p,
                                              input logic [CW-1:0] cap);
        logic [CW-1:0] s;
        s = CW'(p) + CW'(1);
        return (s >= cap) ? '0 : AW'(s);
    endfunction

    function automatic logic [AW-1:0] step_down(input logic [AW-1:0] p,
                                                input logic [CW-1:0] cap);
        logic [CW-1:0] m;
        m = cap - CW'(1);
        return (p == '0) ? AW'(m) : p - AW'(1);
    endfunction

    logic [CAP_W-1:0]  r_cap;
    logic [AW-1:0]     r_front;
    logic [AW-1:0]     r_back;
    logic              r_none;
    logic [AW-1:0]     n_front;
    logic [AW-1:0]     n_back;
    logic              n_none;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd;

    logic              r_res_ok;
    logic              r_res_pop;
    logic              r_res_empty;
    logic              r_res_full;
    t_out_item         r_out_item;

    logic [CW-1:0]     cap_eff;
    logic              cap_on;
    logic              is_push;
    logic              at_front;
    logic              full_now;
    logic              push_ok;
    logic              pop_ok;
    logic [AW-1:0]     waddr;
    logic [AW-1:0]     raddr;
    logic              full_next;

    // capacity saturates at the ring depth
    assign cap_eff  = (CW'(r_cap) > CW'(DEPTH)) ? CW'(DEPTH) : CW'(r_cap);
    assign cap_on   = (cap_eff != '0);
    assign is_push  = (i_in_item.action == ACT_PUSH_FRONT) ||
                      (i_in_item.action == ACT_PUSH_BACK);
    assign at_front = (i_in_item.action == ACT_PUSH_FRONT) ||
                      (i_in_item.action == ACT_POP_FRONT);
    assign full_now = cap_on && !r_none && (r_front == step_up(r_back, cap_eff));
    assign push_ok  = cap_on && is_push && !full_now;
    assign pop_ok   = cap_on && !is_push && !r_none;
    assign raddr    = at_front ? r_front : r_back;

    always_comb begin
        n_front = r_front;
        n_back  = r_back;
        n_none  = r_none;
        if (push_ok) begin
            if (r_none) begin
                n_front = '0;
                n_back  = '0;
                n_none  = 1'b0;
            end else if (at_front) begin
                n_front = step_down(r_front, cap_eff);
            end else begin
                n_back = step_up(r_back, cap_eff);
            end
        end else if (pop_ok) begin
            if (r_front == r_back) begin
                n_front = '0;
                n_back  = '0;
                n_none  = 1'b1;
            end else if (at_front) begin
                n_front = step_up(r_front, cap_eff);
            end else begin
                n_back = step_down(r_back, cap_eff);
            end
        end
        waddr     = at_front ? n_front : n_back;
        full_next = cap_on && !n_none && (n_front == step_up(n_back, cap_eff));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= CAP_RESET;
            r_front <= '0;
            r_back  <= '0;
            r_none  <= 1'b1;
        end else if (i_cmd.cfg_wr) begin
            r_cap   <= i_cfg_data;
            r_front <= '0;
            r_back  <= '0;
            r_none  <= 1'b1;
        end else if (i_cmd.exec) begin
            r_front <= n_front;
            r_back  <= n_back;
            r_none  <= n_none;
        end
    end

    // slot memory, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && push_ok) begin
            r_mem[waddr] <= i_in_item.value;
        end
        if (i_cmd.exec && pop_ok) begin
            r_rd <= r_mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_res_ok    <= push_ok || pop_ok;
            r_res_pop   <= pop_ok;
            r_res_empty <= n_none;
            r_res_full  <= full_next;
        end
        if (i_cmd.load_out) begin
            r_out_item.ok       <= r_res_ok;
            r_out_item.popped   <= r_res_pop ? r_rd : '0;
            r_out_item.is_empty <= r_res_empty;
            r_out_item.is_full  <= r_res_full;
        end
    end

    assign o_out_item = r_out_item;

    a_empty_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_none |-> (r_front == '0) && (r_back == '0))
        else $error("empty ring with pointers away from slot zero");

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_none |-> cap_on && (CW'(r_front) < cap_eff) && (CW'(r_back) < cap_eff))
        else $error("pointer beyond capacity");

    a_refused_still: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec && !i_cmd.cfg_wr && !push_ok && !pop_ok
        |=> $stable(r_front) && $stable(r_back) && $stable(r_none))
        else $error("refused operation changed ring state");

endmodule

// ===== rtl/ring_buffer_deque.sv =====
// ----------------------------------------------------------------------------
// ring_buffer_deque
// bounded double-ended queue held in a ring of slots
// ----------------------------------------------------------------------------
// Each input transfer carries one operation (push front, push back, pop front,
// pop back) and produces exactly one result transfer with ok, the popped value
// (zero unless a pop succeeded) and the empty and full flags after the step.
// On the way from input transfer to result, the pointers and the slot access
// are done in the transfer cycle, and the registered slot read then moves
// into the output register once that is free. The next operation is taken in
// the cycle its predecessor moves to the output register, so with no output
// stall the block sustains one operation per cycle; the output register keeps
// one finished result waiting while the next is worked on. Capacity is
// written through its own port only while no result is pending and no
// operation is offered; a write also empties the deque. Capacity saturates
// at DEPTH, and zero refuses all operations. Refused operations (push into
// full, pop from empty) change nothing and report ok low. No clearing pass
// is needed after reset.
// ----------------------------------------------------------------------------
module ring_buffer_deque #(
    parameter int unsigned DEPTH = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // operation channel
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  rbd_pkg::t_in_item         i_in_item,
    // result channel
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output rbd_pkg::t_out_item        o_out_item,
    // capacity write channel
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [rbd_pkg::CAP_W-1:0] i_cfg_data
);
    import rbd_pkg::*;

    t_dp_cmd cmd;

    // handshakes and sequencing
    rbd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .o_cmd       (cmd)
    );

    // ring pointers, slot storage and result registers
    rbd_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_item  (i_in_item),
        .i_cfg_data (i_cfg_data),
        .o_out_item (o_out_item)
    );

endmodule

// ===== dv/tb_ring_buffer_deque.sv =====
// ----------------------------------------------------------------------------
// tb_ring_buffer_deque
// self-checking testbench for the ring buffer deque
// ----------------------------------------------------------------------------
// A scoreboard class keeps its own copy of the ring, the pointers and the
// capacity, and works out the result of every operation at the moment its
// transfer is accepted. Each result transfer is checked field by field
// against the oldest expected result. Stimulus starts with a short directed
// list (empty and full rings, wrap, zero capacity), then random operation
// bursts, some biased toward pushing or popping. Capacity changes between
// bursts while the block is drained. Both handshake sides idle at random.
// ----------------------------------------------------------------------------
module tb_ring_buffer_deque;

    timeunit 1ns;
    timeprecision 1ps;

    import rbd_pkg::*;

    localparam int unsigned RING_SLOTS = 16;
    localparam int unsigned CYCLE_LIMIT = 400000;

    // reference copy of the deque plus the store of expected results
    class deque_scoreboard;
        logic [DATA_W-1:0] slot_data [RING_SLOTS];
        logic [3:0]        front_ptr;
        logic [3:0]        back_ptr;
        bit                ring_empty;
        logic [CAP_W-1:0]  capacity;
        t_out_item         expected_q [$];
        int errors;
        int ops_seen;
        int ops_refused;
        int pops_done;
        int full_hits;
        int capacity_writes;

        function new();
            foreach (slot_data[i]) slot_data[i] = '0;
            capacity = CAP_RESET;
            clear_ring();
        endfunction

        function void clear_ring();
            front_ptr  = '0;
            back_ptr   = '0;
            ring_empty = 1'b1;
        endfunction

        // slots actually in use, capacity saturates at the ring size
        function int unsigned live_slots();
            return (capacity > RING_SLOTS) ? RING_SLOTS : int'(capacity);
        endfunction

        function logic [3:0] wrap_up(logic [3:0] p, int unsigned n);
            int unsigned q;
            q = int'(p) + 1;
            return (q >= n) ? 4'd0 : q[3:0];
        endfunction

        function logic [3:0] wrap_down(logic [3:0] p, int unsigned n);
            int unsigned q;
            if (n == 0) return 4'd0;
            q = (p == 0) ? n - 1 : int'(p) - 1;
            return q[3:0];
        endfunction

        function bit at_limit(int unsigned n);
            if (n == 0 || ring_empty) return 1'b0;
            return front_ptr == wrap_up(back_ptr, n);
        endfunction

        // a capacity write also empties the deque
        function void write_capacity(logic [CAP_W-1:0] v);
            capacity = v;
            clear_ring();
            capacity_writes++;
        endfunction

        function void note_op(t_in_item op);
            int unsigned n;
            bit          is_push;
            t_out_item   res;
            n       = live_slots();
            is_push = (op.action == ACT_PUSH_FRONT) || (op.action == ACT_PUSH_BACK);
            res     = '0;
            if (n != 0) begin
                if (is_push) begin
                    if (!at_limit(n)) begin
                        if (ring_empty) begin
                            front_ptr  = '0;
                            back_ptr   = '0;
                            ring_empty = 1'b0;
                        end else if (op.action == ACT_PUSH_FRONT) begin
                            front_ptr = wrap_down(front_ptr, n);
                        end else begin
                            back_ptr = wrap_up(back_ptr, n);
                        end
                        if (op.action == ACT_PUSH_FRONT) slot_data[front_ptr] = op.value;
                        else slot_data[back_ptr] = op.value;
                        res.ok = 1'b1;
                    end
                end else if (!ring_empty) begin
                    res.popped = (op.action == ACT_POP_FRONT) ? slot_data[front_ptr]
                                                              : slot_data[back_ptr];
                    if (front_ptr == back_ptr) clear_ring();
                    else if (op.action == ACT_POP_FRONT) front_ptr = wrap_up(front_ptr, n);
                    else back_ptr = wrap_down(back_ptr, n);
                    res.ok = 1'b1;
                    pops_done++;
                end
            end
            res.is_empty = ring_empty;
            res.is_full  = at_limit(n);
            ops_seen++;
            if (!res.ok) ops_refused++;
            if (res.is_full) full_hits++;
            expected_q.push_back(res);
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (expected_q.size() == 0) begin
                $error("result transfer with no operation outstanding");
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.ok !== want.ok) begin
                $error("ok: expected %0d, got %0d", want.ok, got.ok);
                errors++;
            end
            if (got.popped !== want.popped) begin
                $error("popped: expected 0x%08h, got 0x%08h", want.popped, got.popped);
                errors++;
            end
            if (got.is_empty !== want.is_empty) begin
                $error("is_empty: expected %0d, got %0d", want.is_empty, got.is_empty);
                errors++;
            end
            if (got.is_full !== want.is_full) begin
                $error("is_full: expected %0d, got %0d", want.is_full, got.is_full);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    // dut signals, all inputs known from time zero
    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_in_valid  = 1'b0;
    logic             o_in_stall;
    t_in_item         i_in_item   = '0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    t_out_item        o_out_item;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [CAP_W-1:0] i_cfg_data  = '0;

    deque_scoreboard deque_sb;
    int unsigned     cycle_count = 0;
    int unsigned     tx_idle_pct = 0;
    int unsigned     rx_idle_pct = 0;

    ring_buffer_deque #(
        .DEPTH(RING_SLOTS)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    // 12 ns clock
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // watchdog, ends a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("** ring_buffer_deque: FAILED **");
            $finish;
        end
    end

    // result side backpressure, a fresh coin each cycle
    always @(posedge i_clk) begin
        i_out_stall <= (rx_idle_pct != 0) && ($urandom_range(0, 99) < rx_idle_pct);
    end

    // transfer monitor: values seen here are the ones before the edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) deque_sb.check_result(o_out_item);
            if (i_in_valid && !o_in_stall) deque_sb.note_op(i_in_item);
            if (i_cfg_valid && o_cfg_ready) deque_sb.write_capacity(i_cfg_data);
        end
    end

    // one operation transfer, returns just after the accepting edge
    task automatic send_op(input logic [ACTION_W-1:0] act, input logic [DATA_W-1:0] val);
        if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= '{action: act, value: val};
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // stop sending and wait until every result has come back
    task automatic drain();
        i_in_valid <= 1'b0;
        while (deque_sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // random bursts, leaning toward pushes, toward pops or neither, so the ring
    // swings between empty and full
    task automatic run_random(input int count);
        int unsigned       push_pct;
        int unsigned       pick;
        logic [ACTION_W-1:0] act;
        logic [DATA_W-1:0] val;
        push_pct = 50;
        for (int k = 0; k < count; k++) begin
            if (k % 32 == 0) begin
                case ($urandom_range(0, 2))
                    0: push_pct = 20;
                    1: push_pct = 50;
                    default: push_pct = 80;
                endcase
            end
            if ($urandom_range(0, 99) < push_pct)
                act = $urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
            else
                act = $urandom_range(0, 1) ? ACT_POP_BACK : ACT_POP_FRONT;
            pick = $urandom_range(0, 15);
            if (pick == 0) val = '0;
            else if (pick == 1) val = '1;
            else val = $urandom;
            send_op(act, val);
        end
    endtask

    int cap_plan [12] = '{31, 1, 0, 4, 2, 17, 16, 0, 3, 9, 16, 5};

    initial begin
        deque_sb = new();
        tx_idle_pct = 27;
        rx_idle_pct = 61;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty ring at reset capacity
        send_op(ACT_POP_FRONT, 32'h1234_5678);
        send_op(ACT_POP_BACK, '1);
        send_op(ACT_PUSH_FRONT, '0);
        send_op(ACT_PUSH_BACK, '1);
        send_op(ACT_POP_FRONT, '0);
        send_op(ACT_POP_BACK, '0);
        // single slot: full right after one push
        set_capacity(5'd1);
        send_op(ACT_PUSH_BACK, 32'hA5A5_A5A5);
        send_op(ACT_PUSH_FRONT, 32'h5A5A_5A5A);
        send_op(ACT_POP_FRONT, '0);
        // two slots: front pointer wraps below slot 0, push into full, pop empty
        set_capacity(5'd2);
        send_op(ACT_PUSH_BACK, 32'h0000_0001);
        send_op(ACT_PUSH_FRONT, 32'h8000_0000);
        send_op(ACT_PUSH_BACK, 32'hDEAD_BEEF);
        send_op(ACT_POP_BACK, '0);
        send_op(ACT_POP_FRONT, '0);
        send_op(ACT_POP_BACK, '0);
        // zero capacity refuses everything
        set_capacity(5'd0);
        send_op(ACT_PUSH_FRONT, 32'hFFFF_0000);
        send_op(ACT_POP_BACK, '0);

        // random part, three idling phases of four capacity settings each
        for (int s = 0; s < 12; s++) begin
            set_capacity(cap_plan[s][CAP_W-1:0]);
            case (s / 4)
                0: begin
                    tx_idle_pct = 27;
                    rx_idle_pct = 61;
                end
                1: begin
                    tx_idle_pct = 61;
                    rx_idle_pct = 27;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            run_random((cap_plan[s] == 0) ? 12 : 160);
        end

        drain();
        repeat (8) @(posedge i_clk);

        $display("covered %0d operations (%0d refused, %0d pops with data, %0d left full)",
                 deque_sb.ops_seen, deque_sb.ops_refused, deque_sb.pops_done,
                 deque_sb.full_hits);
        $display("across %0d capacity settings including zero, one and above the ring size",
                 deque_sb.capacity_writes);
        if (deque_sb.errors == 0) begin
            $display("** ring_buffer_deque: PASSED **");
        end else begin
            $display("** ring_buffer_deque: FAILED **");
        end
        $finish;
    end

endmodule
